[design/tgr_pkg.sv]
// Shared types and constants for the touch gesture recognizer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package tgr_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_SWIPE_MIN  = 3'd0;
  localparam logic [2:0] REG_TAP_MOVE   = 3'd1;
  localparam logic [2:0] REG_LONG_PRESS = 3'd2;
  localparam logic [2:0] REG_TAP_MIN    = 3'd3;
  localparam logic [2:0] REG_AXIS_MARG  = 3'd4;
  localparam logic [2:0] REG_SWAP_AXES  = 3'd5;
  localparam logic [2:0] REG_MIRROR_X   = 3'd6;
  localparam logic [2:0] REG_MIRROR_Y   = 3'd7;

  // Register reset values
  localparam logic [8:0]  RST_SWIPE_MIN  = 9'd40;
  localparam logic [8:0]  RST_TAP_MOVE   = 9'd16;
  localparam logic [15:0] RST_LONG_PRESS = 16'd1000;
  localparam logic [7:0]  RST_TAP_MIN    = 8'd12;
  localparam logic [7:0]  RST_AXIS_MARG  = 8'd8;

  // Gesture codes
  localparam logic [2:0] GEST_NONE  = 3'd0;
  localparam logic [2:0] GEST_TAP   = 3'd1;
  localparam logic [2:0] GEST_LEFT  = 3'd2;
  localparam logic [2:0] GEST_RIGHT = 3'd3;
  localparam logic [2:0] GEST_UP    = 3'd4;
  localparam logic [2:0] GEST_DOWN  = 3'd5;

  typedef struct packed {
    logic [8:0]  swipe_min;
    logic [8:0]  tap_move;
    logic [15:0] long_press;
    logic [7:0]  tap_min;
    logic [7:0]  axis_margin;
    logic        swap_axes;
    logic        mirror_x;
    logic        mirror_y;
  } cfg_t;

  typedef struct packed {
    logic [2:0] gesture;
    logic [8:0] tap_x;
    logic [7:0] tap_y;
    logic       touching;
    logic [8:0] point_x;
    logic [7:0] point_y;
    logic       swipe_active;
  } res_t;

endpackage

[design/tgr_map.sv]
// Raw portrait point to clamped landscape screen point.
// Depends on tgr_pkg (cfg_t).
`timescale 1ns / 1ps

module tgr_map #(
  parameter int SCREEN_WIDTH  = 320,
  parameter int SCREEN_HEIGHT = 240,
  localparam int XW = $clog2(SCREEN_WIDTH),
  localparam int YW = $clog2(SCREEN_HEIGHT)
) (
  input  tgr_pkg::cfg_t   cfg,
  input  logic [15:0]     raw_x,
  input  logic [15:0]     raw_y,
  output logic [XW-1:0]   map_x,
  output logic [YW-1:0]   map_y
);
  import tgr_pkg::*;

  localparam logic signed [17:0] XMAX = 18'(SCREEN_WIDTH - 1);
  localparam logic signed [17:0] YMAX = 18'(SCREEN_HEIGHT - 1);

  logic signed [17:0] sx0, sy0, sx1, sy1, sx2, sy2;

  always_comb begin
    sx0 = $signed({2'b00, raw_y});
    sy0 = YMAX - $signed({2'b00, raw_x});
    sx1 = cfg.swap_axes ? sy0 : sx0;
    sy1 = cfg.swap_axes ? sx0 : sy0;
    sx2 = cfg.mirror_x ? (XMAX - sx1) : sx1;
    sy2 = cfg.mirror_y ? (YMAX - sy1) : sy1;
    // clamp to the screen
    if (sx2 < 0) begin
      map_x = '0;
    end else if (sx2 > XMAX) begin
      map_x = XMAX[XW-1:0];
    end else begin
      map_x = sx2[XW-1:0];
    end
    if (sy2 < 0) begin
      map_y = '0;
    end else if (sy2 > YMAX) begin
      map_y = YMAX[YW-1:0];
    end else begin
      map_y = sy2[YW-1:0];
    end
  end

endmodule

[design/tgr_track.sv]
// Press tracking state and release classification.
// Depends on tgr_pkg (cfg_t, res_t, gesture codes).
`timescale 1ns / 1ps

module tgr_track #(
  parameter int SCREEN_WIDTH  = 320,
  parameter int SCREEN_HEIGHT = 240,
  localparam int XW = $clog2(SCREEN_WIDTH),
  localparam int YW = $clog2(SCREEN_HEIGHT)
) (
  input  logic           clk,
  input  logic           rst_n,
  input  tgr_pkg::cfg_t  cfg,
  input  logic           accept,
  input  logic           frame_ready,
  input  logic [3:0]     point_count,
  input  logic [31:0]    time_ms,
  input  logic [XW-1:0]  map_x,
  input  logic [YW-1:0]  map_y,
  output tgr_pkg::res_t  res
);
  import tgr_pkg::*;

  localparam int MW = (XW > YW) ? XW : YW;
  localparam int DW = ((MW > 9) ? MW : 9) + 1;

  logic          finger_r, pressed_r, swiping_r;
  logic [XW-1:0] cur_x_r, start_x_r, last_x_r;
  logic [YW-1:0] cur_y_r, start_y_r, last_y_r;
  logic [31:0]   press_time_r;

  logic          new_pt, finger_nxt, swiping_nxt;
  logic [XW-1:0] cur_x_nxt, sx_eff, adx_t, adx_r;
  logic [YW-1:0] cur_y_nxt, sy_eff, ady_t, ady_r;
  logic [XW:0]   dx_t, dx_r;
  logic [YW:0]   dy_t, dy_r;
  logic [DW-1:0] adx_tw, ady_tw, adx_rw, ady_rw, smin_w, marg_w, tmov_w;
  logic [31:0]   dur, lx32, ly32, cx32, cy32;
  logic [2:0]    gest;

  always_comb begin
    new_pt     = frame_ready && (point_count != 4'd0);
    finger_nxt = frame_ready ? (point_count != 4'd0) : finger_r;
    cur_x_nxt  = new_pt ? map_x : cur_x_r;
    cur_y_nxt  = new_pt ? map_y : cur_y_r;

    // travel while pressed; a fresh press starts at the current point
    sx_eff = pressed_r ? start_x_r : cur_x_nxt;
    sy_eff = pressed_r ? start_y_r : cur_y_nxt;
    dx_t   = {1'b0, cur_x_nxt} - {1'b0, sx_eff};
    dy_t   = {1'b0, cur_y_nxt} - {1'b0, sy_eff};
    adx_t  = dx_t[XW] ? XW'(~dx_t + 1'b1) : dx_t[XW-1:0];
    ady_t  = dy_t[YW] ? YW'(~dy_t + 1'b1) : dy_t[YW-1:0];

    // travel of the finished stroke
    dx_r   = {1'b0, last_x_r} - {1'b0, start_x_r};
    dy_r   = {1'b0, last_y_r} - {1'b0, start_y_r};
    adx_r  = dx_r[XW] ? XW'(~dx_r + 1'b1) : dx_r[XW-1:0];
    ady_r  = dy_r[YW] ? YW'(~dy_r + 1'b1) : dy_r[YW-1:0];

    adx_tw = {{(DW-XW){1'b0}}, adx_t};
    ady_tw = {{(DW-YW){1'b0}}, ady_t};
    adx_rw = {{(DW-XW){1'b0}}, adx_r};
    ady_rw = {{(DW-YW){1'b0}}, ady_r};
    smin_w = {{(DW-9){1'b0}}, cfg.swipe_min};
    tmov_w = {{(DW-9){1'b0}}, cfg.tap_move};
    marg_w = {{(DW-8){1'b0}}, cfg.axis_margin};

    swiping_nxt = pressed_r ? swiping_r : 1'b0;
    if (!swiping_nxt && (adx_tw >= smin_w) && (adx_tw > ady_tw)) begin
      swiping_nxt = 1'b1;
    end

    dur  = time_ms - press_time_r;
    gest = GEST_NONE;
    if (!finger_nxt && pressed_r) begin
      if ((adx_rw >= smin_w) && (adx_rw > ady_rw + marg_w)) begin
        gest = dx_r[XW] ? GEST_LEFT : GEST_RIGHT;
      end else if ((ady_rw >= smin_w) && (ady_rw > adx_rw + marg_w)) begin
        gest = dy_r[YW] ? GEST_UP : GEST_DOWN;
      end else if ((dur >= {24'd0, cfg.tap_min}) && (dur < {16'd0, cfg.long_press}) &&
                   (adx_rw <= tmov_w) && (ady_rw <= tmov_w)) begin
        gest = GEST_TAP;
      end
    end

    // widen, then keep the field width
    lx32 = 32'(last_x_r);
    ly32 = 32'(last_y_r);
    cx32 = 32'(cur_x_nxt);
    cy32 = 32'(cur_y_nxt);

    res.gesture      = gest;
    res.tap_x        = (gest == GEST_TAP) ? lx32[8:0] : 9'd0;
    res.tap_y        = (gest == GEST_TAP) ? ly32[7:0] : 8'd0;
    res.touching     = finger_nxt;
    res.point_x      = finger_nxt ? cx32[8:0] : 9'd0;
    res.point_y      = finger_nxt ? cy32[7:0] : 8'd0;
    res.swipe_active = finger_nxt ? swiping_nxt : (pressed_r ? 1'b0 : swiping_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      finger_r     <= 1'b0;
      pressed_r    <= 1'b0;
      swiping_r    <= 1'b0;
      cur_x_r      <= '0;
      cur_y_r      <= '0;
      start_x_r    <= '0;
      start_y_r    <= '0;
      last_x_r     <= '0;
      last_y_r     <= '0;
      press_time_r <= '0;
    end else if (accept) begin
      finger_r <= finger_nxt;
      cur_x_r  <= cur_x_nxt;
      cur_y_r  <= cur_y_nxt;
      if (finger_nxt) begin
        if (!pressed_r) begin
          pressed_r    <= 1'b1;
          press_time_r <= time_ms;
          start_x_r    <= cur_x_nxt;
          start_y_r    <= cur_y_nxt;
        end
        last_x_r  <= cur_x_nxt;
        last_y_r  <= cur_y_nxt;
        swiping_r <= swiping_nxt;
      end else if (pressed_r) begin
        pressed_r <= 1'b0;
        swiping_r <= 1'b0;
      end
    end
  end

endmodule

[design/touch_gesture_recognizer_top.sv]
// Touch gesture recognizer top level: config registers, mapping, tracking, result register.
// Depends on tgr_pkg, tgr_map and tgr_track.
`timescale 1ns / 1ps

// Usage
//   Input channel (in_valid/in_ready): one touch-controller poll per item:
//   frame flag, point count, raw point, millisecond timestamp.
//   Result channel (out_valid/out_ready): exactly one result item per poll:
//   gesture code, tap point, touching flag, current screen point and the
//   swipe-in-progress flag.
//   Configuration port: write cfg_wdata into register cfg_index while cfg_we
//   is high; unknown indexes do not exist (all eight are used). Write only
//   while the block is idle.
// Latency and throughput
//   A poll is mapped, tracked and classified in the cycle it is accepted;
//   its result appears in the output register in the next cycle. One poll is
//   taken per cycle unless the result stalls, set by the single tracking-state update per cycle.
// Reset
//   rst_n (synchronous, active low) loads the register defaults, clears the
//   press state and empties the output register.
// Stall
//   While out_valid is high and out_ready low the result holds and in_ready
//   drops; a new poll is taken in the same cycle the held result leaves.

module touch_gesture_recognizer_top #(
  parameter int SCREEN_WIDTH  = 320,
  parameter int SCREEN_HEIGHT = 240
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  // input items
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_frame_ready,
  input  logic [3:0]  in_point_count,
  input  logic [15:0] in_raw_x,
  input  logic [15:0] in_raw_y,
  input  logic [31:0] in_time_ms,
  // result items
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_gesture,
  output logic [8:0]  out_tap_x,
  output logic [7:0]  out_tap_y,
  output logic        out_touching,
  output logic [8:0]  out_point_x,
  output logic [7:0]  out_point_y,
  output logic        out_swipe_active
);
  import tgr_pkg::*;

  localparam int XW = $clog2(SCREEN_WIDTH);
  localparam int YW = $clog2(SCREEN_HEIGHT);

  cfg_t          cfg_r;
  res_t          res, res_r;
  logic          out_valid_r;
  logic          accept;
  logic [XW-1:0] map_x;
  logic [YW-1:0] map_y;

  // Take a new item whenever the result register is empty or draining.
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.swipe_min   <= RST_SWIPE_MIN;
      cfg_r.tap_move    <= RST_TAP_MOVE;
      cfg_r.long_press  <= RST_LONG_PRESS;
      cfg_r.tap_min     <= RST_TAP_MIN;
      cfg_r.axis_margin <= RST_AXIS_MARG;
      cfg_r.swap_axes   <= 1'b0;
      cfg_r.mirror_x    <= 1'b0;
      cfg_r.mirror_y    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SWIPE_MIN:  cfg_r.swipe_min   <= cfg_wdata[8:0];
        REG_TAP_MOVE:   cfg_r.tap_move    <= cfg_wdata[8:0];
        REG_LONG_PRESS: cfg_r.long_press  <= cfg_wdata;
        REG_TAP_MIN:    cfg_r.tap_min     <= cfg_wdata[7:0];
        REG_AXIS_MARG:  cfg_r.axis_margin <= cfg_wdata[7:0];
        REG_SWAP_AXES:  cfg_r.swap_axes   <= cfg_wdata[0];
        REG_MIRROR_X:   cfg_r.mirror_x    <= cfg_wdata[0];
        REG_MIRROR_Y:   cfg_r.mirror_y    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Map the raw point into screen space
  tgr_map #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_map (
    .cfg   (cfg_r),
    .raw_x (in_raw_x),
    .raw_y (in_raw_y),
    .map_x (map_x),
    .map_y (map_y)
  );

  // Track the press and classify on release; state advances on accept only
  tgr_track #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_track (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .accept      (accept),
    .frame_ready (in_frame_ready),
    .point_count (in_point_count),
    .time_ms     (in_time_ms),
    .map_x       (map_x),
    .map_y       (map_y),
    .res         (res)
  );

  // Result register: load on accept, hold while the receiver stalls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_gesture      = res_r.gesture;
  assign out_tap_x        = res_r.tap_x;
  assign out_tap_y        = res_r.tap_y;
  assign out_touching     = res_r.touching;
  assign out_point_x      = res_r.point_x;
  assign out_point_y      = res_r.point_y;
  assign out_swipe_active = res_r.swipe_active;

endmodule

[design/tgr_checker.sv]
// Port-level assertions for the touch gesture recognizer, bound to the top level.
// Depends on tgr_pkg (gesture codes) and touch_gesture_recognizer_top.
`timescale 1ns / 1ps

module tgr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_gesture,
  input logic [8:0]  out_tap_x,
  input logic [7:0]  out_tap_y,
  input logic        out_touching,
  input logic [8:0]  out_point_x,
  input logic [7:0]  out_point_y,
  input logic        out_swipe_active
);
  import tgr_pkg::*;

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_gesture) && $stable(out_point_x))
    else $error("stalled result changed");

  // A gesture is reported only on release
  a_rel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_gesture != GEST_NONE) |-> !out_touching)
    else $error("gesture reported while touching");

  // Tap point is zero unless the gesture is a tap
  a_tap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_gesture != GEST_TAP) |-> (out_tap_x == 9'd0) && (out_tap_y == 8'd0))
    else $error("tap point without tap");

  // No point and no swipe flag without a finger
  a_pt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_touching |->
      (out_point_x == 9'd0) && (out_point_y == 8'd0) && !out_swipe_active)
    else $error("point or swipe flag without finger");

endmodule

bind touch_gesture_recognizer_top tgr_checker u_tgr_checker (.*);
